@@ rtl/core/ipv_lru_replacement_macros.svh @@
// assertion helpers shared by the replacement core
`ifndef IPV_LRU_REPLACEMENT_MACROS_SVH
`define IPV_LRU_REPLACEMENT_MACROS_SVH

// same-cycle implication, checked outside reset
`define IPV_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IPV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ipv_pkg.sv @@
package ipv_pkg;

    localparam int NUM_WAYS = 8;
    localparam int NUM_SETS = 64;

    localparam int CMD_W    = 2;
    localparam int SET_W    = 6;
    localparam int WAY_W    = 3;
    localparam int IPV_BITS = 3;
    localparam int IPV_W    = 27;

    localparam int POS_W    = $clog2(NUM_WAYS + 1);
    localparam int LANE_W   = $clog2(NUM_WAYS);
    localparam int ROW_AW   = $clog2(NUM_SETS);
    localparam int ROW_W    = NUM_WAYS * POS_W;

    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // register index taken from the word address bit of paddr
    localparam logic REG_IPV_TABLE = 1'b0;

    localparam logic [CMD_W-1:0] CMD_HIT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    typedef logic [POS_W-1:0] t_pos;
    typedef t_pos [NUM_WAYS-1:0] t_row;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [WAY_W-1:0] way;
    } t_op;

    localparam t_row ROW_EMPTY = {NUM_WAYS{POS_W'(NUM_WAYS)}};

    // target position for a given table entry, clamped into the row
    function automatic t_pos ipv_target(input logic [IPV_W-1:0] tbl, input t_pos entry);
        logic [IPV_BITS-1:0] t;
        t_pos                res;
        t = '0;
        for (int e = 0; e <= NUM_WAYS; e++) begin
            if (int'(entry) == e) begin
                t = tbl[e*IPV_BITS +: IPV_BITS];
            end
        end
        if (int'(t) > NUM_WAYS - 1) begin
            res = POS_W'(NUM_WAYS - 1);
        end else begin
            res = POS_W'(t);
        end
        return res;
    endfunction

endpackage

@@ rtl/core/ipv_req_if.sv @@
interface ipv_req_if
    import ipv_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [SET_W-1:0] set_index;
    logic [WAY_W-1:0] way;

    modport source (output valid, output command, output set_index, output way,
                    input ready);
    modport sink   (input valid, input command, input set_index, input way,
                    output ready);
endinterface

@@ rtl/core/ipv_rsp_if.sv @@
interface ipv_rsp_if
    import ipv_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [WAY_W-1:0] victim_way;

    modport source (output valid, output victim_way, input ready);
    modport sink   (input valid, input victim_way, output ready);
endinterface

@@ rtl/core/ipv_lru_replacement.sv @@
// Recency-position replacement core with a programmable insertion/promotion
// vector. Each transaction (hit, fill or victim query) reads its set's row
// from a single row memory in the accept cycle, and in the next cycle the row
// is updated and written back or searched for the victim, so one transaction
// is taken per clock. The row written in one cycle is forwarded to a
// transaction on the same set that entered at that edge. A victim query holds
// the update stage, and with it the input, while a previous result waits
// in the output register. Rows are tracked by per-set valid bits, so all
// ways read as empty right after reset with no clearing pass. The vector is
// written at byte address 0 and must only change while the core is idle.
module ipv_lru_replacement
    import ipv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    ipv_req_if.sink            in_ch,
    ipv_rsp_if.source          out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

`include "ipv_lru_replacement_macros.svh"

    logic [IPV_W-1:0]  r_ipv;

    logic              r_s1_vld;
    t_op               r_s1_op;
    logic [ROW_AW-1:0] r_s1_set;
    logic              r_fwd_vld;
    t_row              r_fwd_row;
    logic              r_row_vld [NUM_SETS];
    logic              r_out_vld;
    logic [WAY_W-1:0]  r_out_way;

    logic              in_acc;
    logic [ROW_AW-1:0] in_set;
    logic              s1_query;
    logic              s1_done;
    logic              ram_we;
    logic              calc_we;
    t_row              ram_row;
    t_row              cur_row;
    t_row              new_row;
    logic [WAY_W-1:0]  victim;
    logic              row_ok;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ipv <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr[PADDR_W-1] == REG_IPV_TABLE) begin
            r_ipv <= pwdata[IPV_W-1:0];
        end
    end

    assign prdata = (paddr[PADDR_W-1] == REG_IPV_TABLE) ?
                    PDATA_W'(r_ipv) : '0;

    // pipeline control
    assign in_set   = in_ch.set_index[ROW_AW-1:0];
    assign in_acc   = in_ch.valid && in_ch.ready;
    assign s1_query = r_s1_vld && (r_s1_op.cmd == CMD_QUERY);
    assign s1_done  = r_s1_vld && (!s1_query || !r_out_vld || out_ch.ready);
    assign ram_we   = r_s1_vld && calc_we;

    assign in_ch.ready = !r_s1_vld || s1_done;

    ipv_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_set),
        .i_wdata (new_row),
        .i_re    (in_acc),
        .i_raddr (in_set),
        .o_rdata (ram_row)
    );

    // the write at the accept edge is not seen by that edge's read
    assign cur_row = r_fwd_vld ? r_fwd_row :
                     (r_row_vld[r_s1_set] ? ram_row : ROW_EMPTY);

    ipv_row_calc u_calc (
        .i_row    (cur_row),
        .i_op     (r_s1_op),
        .i_ipv    (r_ipv),
        .o_row    (new_row),
        .o_we     (calc_we),
        .o_victim (victim)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld  <= 1'b1;
            r_fwd_vld <= ram_we && (r_s1_set == in_set);
        end else if (s1_done) begin
            r_s1_vld  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op.cmd <= in_ch.command;
            r_s1_op.way <= in_ch.way;
            r_s1_set    <= in_set;
            r_fwd_row   <= new_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SETS; s++) begin
                r_row_vld[s] <= 1'b0;
            end
        end else if (ram_we) begin
            r_row_vld[r_s1_set] <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_done && s1_query) begin
            r_out_vld <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done && s1_query) begin
            r_out_way <= victim;
        end
    end

    assign out_ch.valid      = r_out_vld;
    assign out_ch.victim_way = r_out_way;

    always_comb begin
        row_ok = 1'b1;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (int'(new_row[w]) > NUM_WAYS) begin
                row_ok = 1'b0;
            end
        end
    end

    `IPV_ASSERT(a_query_no_write, i_clk, i_rst_n, s1_query, !ram_we, "query wrote a row")
    `IPV_ASSERT(a_out_not_lost, i_clk, i_rst_n, s1_done && s1_query,
                !r_out_vld || out_ch.ready, "victim result overwritten")
    `IPV_ASSERT_NEXT(a_query_result, i_clk, i_rst_n, s1_done && s1_query, r_out_vld,
                     "finished query left no result")
    `IPV_ASSERT(a_row_in_range, i_clk, i_rst_n, ram_we, row_ok,
                "written position beyond way count")

endmodule

@@ rtl/core/ipv_ram.sv @@
module ipv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/ipv_row_calc.sv @@
module ipv_row_calc
    import ipv_pkg::*;
(
    input  t_row             i_row,
    input  t_op              i_op,
    input  logic [IPV_W-1:0] i_ipv,
    output t_row             o_row,
    output logic             o_we,
    output logic [WAY_W-1:0] o_victim
);

    logic              is_hit;
    logic              is_fill;
    logic              way_ok;
    logic [LANE_W-1:0] lane;
    t_pos              entry;
    t_pos              target;
    t_pos              best_pos;
    logic [WAY_W-1:0]  best;

    always_comb begin
        is_hit  = (i_op.cmd == CMD_HIT);
        is_fill = (i_op.cmd == CMD_FILL);
        way_ok  = (int'(i_op.way) < NUM_WAYS);
        lane    = i_op.way[LANE_W-1:0];

        // a hit indexes by old position, a fill by the empty position;
        // that index is also the upper bound of the aging window
        entry  = is_hit ? i_row[lane] : POS_W'(NUM_WAYS);
        target = ipv_target(i_ipv, entry);

        o_row = i_row;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (i_row[w] >= target && i_row[w] < entry) begin
                o_row[w] = i_row[w] + 1'b1;
            end
        end
        o_row[lane] = target;

        o_we = (is_hit || is_fill) && way_ok;

        // strict compare keeps the lowest way among equal maxima
        best     = '0;
        best_pos = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (i_row[w] > best_pos) begin
                best_pos = i_row[w];
                best     = WAY_W'(w);
            end
        end
        o_victim = best;
    end

endmodule
